### rtl/core/code_only_phrase_search_macros.svh
// Assertion helpers shared by cops_front and cops_back.
`ifndef CODE_ONLY_PHRASE_SEARCH_MACROS_SVH
`define CODE_ONLY_PHRASE_SEARCH_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define COPS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define COPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/cops_pkg.sv
`timescale 1ns / 1ps
package cops_pkg;

  localparam int MAX_PATTERN = 16;
  localparam int MAX_DELIM   = 16;
  localparam int LINE_W      = 32;
  localparam int PLEN_W      = 5;
  localparam int DLEN_W      = $clog2(MAX_DELIM + 1);
  localparam int CNT_W       = $clog2(MAX_PATTERN + 2);
  localparam int CODE_CAP    = MAX_PATTERN + 1;
  localparam int RAW_CMP     = MAX_DELIM + 1;
  localparam int FIFO_DEPTH  = 2;
  localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
  localparam int CFG_W       = 64;
  localparam int CFG_IDX_W   = 2;

  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_UND   = 8'h5F;

  typedef enum logic [1:0] {
    FUNC_CHAR = 2'd0,
    FUNC_EOL  = 2'd1,
    FUNC_SOF  = 2'd2
  } func_code_t;

  typedef enum logic [1:0] {
    KIND_CHAR,
    KIND_EOL,
    KIND_SOF
  } item_kind_t;

  typedef enum logic [2:0] {
    MODE_CODE,
    MODE_LINE,
    MODE_BLOCK,
    MODE_STRING,
    MODE_CHAR,
    MODE_RAW
  } lex_mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_LOW    = 2'd0,
    CFG_PATTERN_HIGH   = 2'd1,
    CFG_PATTERN_LENGTH = 2'd2,
    CFG_WHOLE_WORD     = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    item_kind_t kind;
    logic [7:0] char_byte;
  } item_t;

  typedef struct packed {
    logic [63:0]       pattern_low;
    logic [63:0]       pattern_high;
    logic [PLEN_W-1:0] pattern_length;
    logic              whole_word;
  } cfg_t;

  function automatic logic is_word(input logic [7:0] b);
    return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
           (b >= 8'h61 && b <= 8'h7A) || b == CH_UND;
  endfunction

endpackage

### rtl/core/cops_front.sv
`timescale 1ns / 1ps
module cops_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [1:0]      in_func,
  input  logic [7:0]      in_char_byte,
  output cops_pkg::item_t item,
  output logic            item_valid,
  input  logic            item_pop
);
  import cops_pkg::*;

  `include "code_only_phrase_search_macros.svh"

  item_t              mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [FIFO_AW:0]   cnt_r, cnt_nxt;
  logic               accept, keep, push;
  item_t              cls;

  // Unused func code is taken and dropped here.
  always_comb begin
    keep     = 1'b1;
    cls.kind = KIND_CHAR;
    cls.char_byte = in_char_byte;
    unique case (in_func)
      FUNC_CHAR: cls.kind = KIND_CHAR;
      FUNC_EOL:  cls.kind = KIND_EOL;
      FUNC_SOF:  cls.kind = KIND_SOF;
      default:   keep = 1'b0;
    endcase
  end

  assign in_stall   = (cnt_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign accept     = in_valid && !in_stall;
  assign push       = accept && keep;
  assign item_valid = (cnt_r != '0);
  assign item       = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? FIFO_AW'(wp_r + 1'b1) : wp_r;
    rp_nxt  = item_pop ? FIFO_AW'(rp_r + 1'b1) : rp_r;
    cnt_nxt = cnt_r;
    if (push && !item_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && item_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= cls;
    end
  end

  `COPS_ASSERT_NOW(a_no_pop_empty, item_pop, cnt_r != '0, "pop from empty queue")
  `COPS_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= (FIFO_AW+1)'(FIFO_DEPTH), "queue count overrun")
  `COPS_ASSERT_NEXT(a_push_fills, push && !item_pop, item_valid, "pushed word not visible")

endmodule

### rtl/core/cops_back.sv
`timescale 1ns / 1ps
module cops_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cops_pkg::item_t               item,
  input  logic                          item_valid,
  output logic                          item_pop,
  input  cops_pkg::cfg_t                cfg,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [cops_pkg::LINE_W-1:0]   out_line_number,
  output logic                          out_line_matched
);
  import cops_pkg::*;

  `include "code_only_phrase_search_macros.svh"

  lex_mode_t         mode_r, mode_nxt, j_mode;
  logic              esc_r, esc_nxt, j_esc;
  logic [7:0]        held_r, held_nxt;
  logic              held_v_r, held_v_nxt;
  logic              coll_r, coll_nxt;
  logic [DLEN_W-1:0] dlen_r, dlen_nxt;
  logic              ovf_r, ovf_nxt;
  logic [7:0]        exp_r [RAW_CMP];
  logic [7:0]        exp_nxt [RAW_CMP];
  logic [7:0]        rawwin_r [RAW_CMP];
  logic [7:0]        rawwin_nxt [RAW_CMP];
  logic [7:0]        codewin_r [MAX_PATTERN];
  logic [7:0]        codewin_nxt [MAX_PATTERN];
  logic [CNT_W-1:0]  ccount_r, ccount_nxt, count_n;
  logic              cand_r, cand_nxt, seen_r, seen_nxt;
  logic [LINE_W-1:0] line_r, line_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [LINE_W-1:0] out_num_r, out_num_nxt;
  logic              out_hit_r, out_hit_nxt;

  logic              fire, is_chr, is_eol, is_sof, j_act;
  logic [7:0]        c, n, b;
  logic              rq, sl2, sb, dq, sq;
  logic              consumed, push_code, push_raw, raw_start;
  logic              raw_hit, raw_ok;
  logic [PLEN_W-1:0] eff_len;
  logic [127:0]      pat;
  logic [7:0]        q [MAX_PATTERN];
  logic [7:0]        winn [MAX_PATTERN];
  logic [PLEN_W-1:0] kidx;
  logic [PLEN_W-1:0] nidx;
  logic              cmp_ok, hit, ww_ok;
  logic [7:0]        nbr;

  assign fire     = item_valid && (!out_valid_r || !out_stall);
  assign item_pop = fire;
  assign is_chr   = fire && item.kind == KIND_CHAR;
  assign is_eol   = fire && item.kind == KIND_EOL;
  assign is_sof   = fire && item.kind == KIND_SOF;
  assign b        = item.char_byte;
  assign j_act    = held_v_r && ((is_chr && !coll_r) || is_eol);
  assign c        = held_r;
  assign n        = is_chr ? b : 8'h00;

  assign rq  = c == CH_R && n == CH_DQ;
  assign sl2 = c == CH_SLASH && n == CH_SLASH;
  assign sb  = c == CH_SLASH && n == CH_STAR;
  assign dq  = c == CH_DQ;
  assign sq  = c == CH_SQ;

  // Raw close: window holds ')' + delimiter just before this quote.
  always_comb begin
    raw_ok = 1'b1;
    for (int m = 0; m < RAW_CMP; m++) begin
      if (m <= int'(dlen_r) && rawwin_r[m] != exp_r[m]) begin
        raw_ok = 1'b0;
      end
    end
    raw_hit = dq && !ovf_r && raw_ok;
  end

  // Phrase compare, right-aligned on the newest code byte.
  always_comb begin
    pat     = {cfg.pattern_high, cfg.pattern_low};
    eff_len = (cfg.pattern_length > PLEN_W'(MAX_PATTERN)) ?
              PLEN_W'(MAX_PATTERN) : cfg.pattern_length;
    count_n = (ccount_r < CNT_W'(CODE_CAP)) ? CNT_W'(ccount_r + 1'b1) : ccount_r;
    cmp_ok  = 1'b1;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      kidx    = PLEN_W'(eff_len - PLEN_W'(1) - PLEN_W'(i));
      q[i]    = pat[{kidx[3:0], 3'b000} +: 8];
      winn[i] = (i == 0) ? c : codewin_r[(i == 0) ? 0 : i - 1];
      if (PLEN_W'(i) < eff_len && winn[i] != q[i]) begin
        cmp_ok = 1'b0;
      end
    end
    hit   = eff_len != '0 && CNT_W'(eff_len) <= count_n && cmp_ok;
    nidx  = PLEN_W'(eff_len - PLEN_W'(1));
    nbr   = codewin_r[nidx[3:0]];
    ww_ok = count_n == CNT_W'(eff_len) || !is_word(nbr);
  end

  // Lexer next state
  always_comb begin
    j_mode = mode_r;
    if (j_act) begin
      unique case (mode_r) inside
        MODE_CODE: begin
          if (rq) j_mode = MODE_RAW;
          else if (sl2) j_mode = MODE_LINE;
          else if (sb) j_mode = MODE_BLOCK;
          else if (dq) j_mode = MODE_STRING;
          else if (sq) j_mode = MODE_CHAR;
        end
        MODE_BLOCK: begin
          if (c == CH_STAR && n == CH_SLASH) j_mode = MODE_CODE;
        end
        MODE_STRING, MODE_CHAR: begin
          if (!esc_r && c == ((mode_r == MODE_STRING) ? CH_DQ : CH_SQ)) begin
            j_mode = MODE_CODE;
          end
        end
        MODE_RAW: begin
          if (raw_hit) j_mode = MODE_CODE;
        end
        default: ;
      endcase
    end
    mode_nxt = j_mode;
    if (is_sof) begin
      mode_nxt = MODE_CODE;
    end else if (is_eol && j_mode == MODE_LINE) begin
      mode_nxt = MODE_CODE;
    end
  end

  // Lexer outputs
  always_comb begin
    consumed  = 1'b0;
    push_code = 1'b0;
    push_raw  = 1'b0;
    raw_start = 1'b0;
    j_esc     = esc_r;
    if (j_act) begin
      unique case (mode_r) inside
        MODE_CODE: begin
          consumed  = rq || sl2 || sb;
          raw_start = rq;
          if (!(rq || sl2 || sb)) begin
            if (dq || sq) j_esc = 1'b0;
            else push_code = 1'b1;
          end
        end
        MODE_BLOCK: consumed = c == CH_STAR && n == CH_SLASH;
        MODE_STRING, MODE_CHAR: begin
          if (esc_r) j_esc = 1'b0;
          else if (c == CH_BSL) j_esc = 1'b1;
        end
        MODE_RAW: push_raw = 1'b1;
        default: ;
      endcase
    end
  end

  // Datapath
  always_comb begin
    esc_nxt     = esc_r;
    held_nxt    = held_r;
    held_v_nxt  = held_v_r;
    coll_nxt    = coll_r;
    dlen_nxt    = dlen_r;
    ovf_nxt     = ovf_r;
    exp_nxt     = exp_r;
    rawwin_nxt  = rawwin_r;
    codewin_nxt = codewin_r;
    ccount_nxt  = ccount_r;
    cand_nxt    = cand_r;
    seen_nxt    = seen_r;
    line_nxt    = line_r;
    out_num_nxt = out_num_r;
    out_hit_nxt = out_hit_r;
    out_valid_nxt = out_valid_r && out_stall;

    if (push_code) begin
      for (int i = MAX_PATTERN - 1; i > 0; i--) codewin_nxt[i] = codewin_r[i-1];
      codewin_nxt[0] = c;
      ccount_nxt = count_n;
      seen_nxt   = seen_r || (cand_r && !is_word(c));
      cand_nxt   = 1'b0;
      if (hit) begin
        if (!cfg.whole_word) seen_nxt = 1'b1;
        else if (ww_ok) cand_nxt = 1'b1;
      end
    end
    if (push_raw) begin
      for (int m = RAW_CMP - 1; m > 0; m--) rawwin_nxt[m] = rawwin_r[m-1];
      rawwin_nxt[0] = c;
    end
    if (raw_start) begin
      dlen_nxt = '0;
      coll_nxt = 1'b1;
      for (int m = 0; m < RAW_CMP; m++) rawwin_nxt[m] = 8'h00;
      exp_nxt[0] = CH_RPAR;
    end
    if (j_act) esc_nxt = j_esc;

    if (is_chr) begin
      if (coll_r) begin
        if (b == CH_LPAR) begin
          coll_nxt = 1'b0;
        end else if (dlen_r < DLEN_W'(MAX_DELIM)) begin
          for (int m = RAW_CMP - 1; m > 0; m--) exp_nxt[m] = exp_r[m-1];
          exp_nxt[0] = b;
          dlen_nxt   = DLEN_W'(dlen_r + 1'b1);
        end else begin
          ovf_nxt = 1'b1;
        end
      end else if (j_act && consumed) begin
        held_v_nxt = 1'b0;
      end else begin
        held_nxt   = b;
        held_v_nxt = 1'b1;
      end
    end

    if (is_eol) begin
      held_v_nxt    = 1'b0;
      line_nxt      = line_r + LINE_W'(line_r != '1);
      out_num_nxt   = line_nxt;
      out_hit_nxt   = seen_nxt || cand_nxt;
      out_valid_nxt = 1'b1;
    end

    if (is_sof) begin
      held_v_nxt = 1'b0;
      held_nxt   = 8'h00;
      ovf_nxt    = 1'b0;
      dlen_nxt   = '0;
      line_nxt   = '0;
    end

    if (is_eol || is_sof) begin
      for (int i = 0; i < MAX_PATTERN; i++) codewin_nxt[i] = 8'h00;
      for (int m = 0; m < RAW_CMP; m++) rawwin_nxt[m] = 8'h00;
      ccount_nxt = '0;
      cand_nxt   = 1'b0;
      seen_nxt   = 1'b0;
      esc_nxt    = 1'b0;
      coll_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_CODE;
      esc_r       <= 1'b0;
      held_r      <= 8'h00;
      held_v_r    <= 1'b0;
      coll_r      <= 1'b0;
      dlen_r      <= '0;
      ovf_r       <= 1'b0;
      ccount_r    <= '0;
      cand_r      <= 1'b0;
      seen_r      <= 1'b0;
      line_r      <= '0;
      out_valid_r <= 1'b0;
      for (int m = 0; m < RAW_CMP; m++) rawwin_r[m] <= 8'h00;
      for (int i = 0; i < MAX_PATTERN; i++) codewin_r[i] <= 8'h00;
    end else begin
      mode_r      <= mode_nxt;
      esc_r       <= esc_nxt;
      held_r      <= held_nxt;
      held_v_r    <= held_v_nxt;
      coll_r      <= coll_nxt;
      dlen_r      <= dlen_nxt;
      ovf_r       <= ovf_nxt;
      ccount_r    <= ccount_nxt;
      cand_r      <= cand_nxt;
      seen_r      <= seen_nxt;
      line_r      <= line_nxt;
      out_valid_r <= out_valid_nxt;
      rawwin_r    <= rawwin_nxt;
      codewin_r   <= codewin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    exp_r     <= exp_nxt;
    out_num_r <= out_num_nxt;
    out_hit_r <= out_hit_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_line_number  = out_num_r;
  assign out_line_matched = out_hit_r;

  `COPS_ASSERT_NEXT(a_eol_result, is_eol, out_valid_r, "line end gave no word")
  `COPS_ASSERT_NEXT(a_sof_clean, is_sof, mode_r == MODE_CODE && !held_v_r && line_r == '0, "file start left state")
  `COPS_ASSERT_NOW(a_dlen_bound, 1'b1, dlen_r <= DLEN_W'(MAX_DELIM), "delimiter length overrun")
  `COPS_ASSERT_NOW(a_no_fire_blocked, out_valid_r && out_stall, !item_pop, "item taken while result blocked")

endmodule

### rtl/core/code_only_phrase_search.sv
`timescale 1ns / 1ps
// Channel   Ports                                   Direction
// in        in_valid/in_stall, in_func, in_char_byte  into block
// out       out_valid/out_stall, out_line_number,     out of block
//           out_line_matched
// cfg       cfg_we, cfg_index, cfg_wdata               into block
//
// One item per cycle sustained while out_stall is low; a line end's word is first written to the queue,
// then the lexer/matcher stage takes it and loads its result into the output register.
// A two-word queue decouples intake from the lexer; in_stall rises only when it is full.
// out_stall holds the output register and the lexer; intake keeps going until the queue fills.
// Reset is synchronous; no clearing pass, the block takes words right after reset.
module code_only_phrase_search (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          in_func,
  input  logic [7:0]                          in_char_byte,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [cops_pkg::LINE_W-1:0]         out_line_number,
  output logic                                out_line_matched,
  input  logic                                cfg_we,
  input  logic [cops_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cops_pkg::CFG_W-1:0]          cfg_wdata
);
  import cops_pkg::*;

  cfg_t  cfg_r, cfg_nxt;
  item_t item;
  logic  item_valid, item_pop;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_PATTERN_LOW:    cfg_nxt.pattern_low    = cfg_wdata;
        CFG_PATTERN_HIGH:   cfg_nxt.pattern_high   = cfg_wdata;
        CFG_PATTERN_LENGTH: cfg_nxt.pattern_length = cfg_wdata[PLEN_W-1:0];
        CFG_WHOLE_WORD:     cfg_nxt.whole_word     = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pattern_low    <= '0;
      cfg_r.pattern_high   <= '0;
      cfg_r.pattern_length <= PLEN_W'(1);
      cfg_r.whole_word     <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  cops_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_func      (in_func),
    .in_char_byte (in_char_byte),
    .item         (item),
    .item_valid   (item_valid),
    .item_pop     (item_pop)
  );

  cops_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .item             (item),
    .item_valid       (item_valid),
    .item_pop         (item_pop),
    .cfg              (cfg_r),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_line_number  (out_line_number),
    .out_line_matched (out_line_matched)
  );

endmodule

### tb/code_only_phrase_search_tb.sv
`timescale 1ns / 1ps
module code_only_phrase_search_tb;
  import cops_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES = 200;
  localparam int DIR_ROWS = 41;

  typedef struct {
    logic [1:0]  fn;
    logic [7:0]  ch;
    bit          typed;
    logic [31:0] num;
    bit          hit;
  } src_word_t;

  typedef struct {
    logic [31:0] num;
    bit          hit;
  } line_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_func = '0;
  logic [7:0] in_char_byte = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [LINE_W-1:0] out_line_number;
  logic out_line_matched;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  always #5 clk = ~clk;

  code_only_phrase_search i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_func(in_func), .in_char_byte(in_char_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_line_number(out_line_number), .out_line_matched(out_line_matched),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // search predictor: registers and lexer state
  logic [63:0] p_lo, p_hi;
  logic [4:0]  p_len;
  bit          p_ww;
  lex_mode_t   mode;
  bit          esc, held_v, collect, dovf, cand, seen;
  logic [7:0]  held;
  logic [7:0]  dstore [MAX_DELIM];
  int          dlen;
  logic [7:0]  rawwin [MAX_DELIM + 2];
  logic [7:0]  codewin [MAX_PATTERN + 1];
  int          ccount;
  logic [31:0] lines;

  src_word_t feed_q[$];
  line_res_t line_q[$];
  src_word_t cur_word;
  int errors = 0, accepted = 0, lines_seen = 0, hits_seen = 0, idle_cycles = 0;
  bit calm = 0, hold_req = 0;
  logic [7:0] phrase [16];
  string alpha = "ab_R/*\\'\"() x";

  // directed words under the reset phrase (a single NUL byte)
  src_word_t dir_tab [DIR_ROWS] = '{
    '{FUNC_EOL, 8'h00, 1'b1, 32'd1, 1'b0},
    '{FUNC_CHAR, 8'h00, 1'b0, 32'd0, 1'b0},
    '{FUNC_EOL, 8'h00, 1'b1, 32'd2, 1'b1},
    '{FUNC_CHAR, 8'hFF, 1'b0, 32'd0, 1'b0},
    '{FUNC_EOL, 8'h00, 1'b1, 32'd3, 1'b0},
    '{FUNC_UNUSED, 8'h55, 1'b0, 32'd0, 1'b0},
    '{FUNC_CHAR, CH_SLASH, 1'b0, 32'd0, 1'b0},
    '{FUNC_CHAR, CH_SLASH, 1'b0, 32'd0, 1'b0},
    '{FUNC_CHAR, 8'h00, 1'b0, 32'd0, 1'b0},
    '{FUNC_EOL, 8'h00, 1'b0, 32'd0, 1'b0},
    '{FUNC_CHAR, CH_SLASH, 1'b0, 32'd0, 1'b0},
    '{FUNC_CHAR, CH_STAR, 1'b0, 32'd0, 1'b0},
    '{FUNC_CHAR, 8'h00, 1'b0, 32'd0, 1'b0},
    '{FUNC_CHAR, CH_STAR, 1'b0, 32'd0, 1'b0},
    '{FUNC_CHAR, CH_SLASH, 1'b0, 32'd0, 1'b0},
    '{FUNC_CHAR, 8'h00, 1'b0, 32'd0, 1'b0},
    '{FUNC_EOL, 8'h00, 1'b0, 32'd0, 1'b0},
    '{FUNC_CHAR, CH_DQ, 1'b0, 32'd0, 1'b0},
    '{FUNC_CHAR, CH_BSL, 1'b0, 32'd0, 1'b0},
    '{FUNC_CHAR, CH_DQ, 1'b0, 32'd0, 1'b0},
    '{FUNC_CHAR, 8'h00, 1'b0, 32'd0, 1'b0},
    '{FUNC_CHAR, CH_DQ, 1'b0, 32'd0, 1'b0},
    '{FUNC_CHAR, CH_SQ, 1'b0, 32'd0, 1'b0},
    '{FUNC_CHAR, CH_BSL, 1'b0, 32'd0, 1'b0},
    '{FUNC_CHAR, CH_SQ, 1'b0, 32'd0, 1'b0},
    '{FUNC_CHAR, CH_SQ, 1'b0, 32'd0, 1'b0},
    '{FUNC_EOL, 8'hAA, 1'b0, 32'd0, 1'b0},
    '{FUNC_CHAR, CH_R, 1'b0, 32'd0, 1'b0},
    '{FUNC_CHAR, CH_DQ, 1'b0, 32'd0, 1'b0},
    '{FUNC_CHAR, 8'h61, 1'b0, 32'd0, 1'b0},
    '{FUNC_CHAR, 8'h62, 1'b0, 32'd0, 1'b0},
    '{FUNC_CHAR, CH_LPAR, 1'b0, 32'd0, 1'b0},
    '{FUNC_CHAR, 8'h00, 1'b0, 32'd0, 1'b0},
    '{FUNC_CHAR, CH_RPAR, 1'b0, 32'd0, 1'b0},
    '{FUNC_CHAR, 8'h61, 1'b0, 32'd0, 1'b0},
    '{FUNC_CHAR, 8'h62, 1'b0, 32'd0, 1'b0},
    '{FUNC_CHAR, CH_DQ, 1'b0, 32'd0, 1'b0},
    '{FUNC_CHAR, 8'h00, 1'b0, 32'd0, 1'b0},
    '{FUNC_EOL, 8'h00, 1'b0, 32'd0, 1'b0},
    '{FUNC_SOF, 8'h00, 1'b0, 32'd0, 1'b0},
    '{FUNC_EOL, 8'h00, 1'b1, 32'd1, 1'b0}
  };

  function automatic bit word_byte(logic [7:0] b);
    return (b >= "0" && b <= "9") || (b >= "A" && b <= "Z") ||
           (b >= "a" && b <= "z") || b == CH_UND;
  endfunction

  function automatic logic [7:0] phrase_at(int j);
    logic [63:0] w;
    w = (j < 8) ? p_lo : p_hi;
    return w[(j % 8) * 8 +: 8];
  endfunction

  function automatic void clear_line();
    foreach (codewin[k]) codewin[k] = '0;
    foreach (rawwin[k]) rawwin[k] = '0;
    ccount = 0;
    cand = 0;
    seen = 0;
    esc = 0;
    collect = 0;
  endfunction

  function automatic void code_push(logic [7:0] b);
    int len;
    bit hit;
    hit = 1;
    len = (p_len > MAX_PATTERN) ? MAX_PATTERN : p_len;
    if (cand && !word_byte(b)) seen = 1;
    cand = 0;
    for (int k = MAX_PATTERN; k > 0; k--) codewin[k] = codewin[k-1];
    codewin[0] = b;
    if (ccount < MAX_PATTERN + 1) ccount++;
    if (len == 0 || ccount < len) return;
    for (int j = 0; j < len; j++)
      if (codewin[len-1-j] != phrase_at(j)) hit = 0;
    if (!hit) return;
    if (!p_ww) seen = 1;
    else if (ccount == len || !word_byte(codewin[len])) cand = 1;
  endfunction

  function automatic void raw_push(logic [7:0] b);
    bit hit;
    for (int k = MAX_DELIM + 1; k > 0; k--) rawwin[k] = rawwin[k-1];
    rawwin[0] = b;
    if (b != CH_DQ || dovf || dlen > MAX_DELIM) return;
    hit = rawwin[dlen+1] == CH_RPAR;
    for (int j = 0; j < dlen; j++)
      if (rawwin[dlen-j] != dstore[j]) hit = 0;
    if (hit) mode = MODE_CODE;
  endfunction

  // judge held byte c against follower n; 1 means n is consumed
  function automatic bit judge(logic [7:0] c, logic [7:0] n);
    case (mode)
      MODE_CODE: begin
        if (c == CH_R && n == CH_DQ) begin
          mode = MODE_RAW;
          dlen = 0;
          collect = 1;
          foreach (rawwin[k]) rawwin[k] = '0;
          return 1;
        end
        if (c == CH_SLASH && n == CH_SLASH) begin
          mode = MODE_LINE;
          return 1;
        end
        if (c == CH_SLASH && n == CH_STAR) begin
          mode = MODE_BLOCK;
          return 1;
        end
        if (c == CH_DQ) begin
          mode = MODE_STRING;
          esc = 0;
        end else if (c == CH_SQ) begin
          mode = MODE_CHAR;
          esc = 0;
        end else code_push(c);
        return 0;
      end
      MODE_BLOCK: begin
        if (c == CH_STAR && n == CH_SLASH) begin
          mode = MODE_CODE;
          return 1;
        end
        return 0;
      end
      MODE_STRING, MODE_CHAR: begin
        if (esc) esc = 0;
        else if (c == CH_BSL) esc = 1;
        else if (c == ((mode == MODE_STRING) ? CH_DQ : CH_SQ)) mode = MODE_CODE;
        return 0;
      end
      MODE_RAW: begin
        raw_push(c);
        return 0;
      end
      default: return 0;
    endcase
  endfunction

  function automatic void search_reset();
    p_lo = '0;
    p_hi = '0;
    p_len = 5'd1;
    p_ww = 0;
    mode = MODE_CODE;
    held_v = 0;
    held = '0;
    dovf = 0;
    dlen = 0;
    foreach (dstore[k]) dstore[k] = '0;
    lines = '0;
    clear_line();
  endfunction

  function automatic bit search_step(logic [1:0] fn, logic [7:0] b, output line_res_t r);
    r = '{default: '0};
    case (fn)
      FUNC_CHAR: begin
        if (collect) begin
          if (b == CH_LPAR) collect = 0;
          else if (dlen < MAX_DELIM) begin
            dstore[dlen] = b;
            dlen++;
          end else dovf = 1;
        end else if (held_v && judge(held, b)) held_v = 0;
        else begin
          held = b;
          held_v = 1;
        end
        return 0;
      end
      FUNC_EOL: begin
        if (held_v) void'(judge(held, 8'h00));
        held_v = 0;
        if (mode == MODE_LINE) mode = MODE_CODE;
        if (cand) seen = 1;
        if (lines != 32'hFFFF_FFFF) lines++;
        r.num = lines;
        r.hit = seen;
        clear_line();
        return 1;
      end
      FUNC_SOF: begin
        mode = MODE_CODE;
        held_v = 0;
        held = '0;
        dovf = 0;
        dlen = 0;
        lines = '0;
        clear_line();
        return 0;
      end
      default: return 0;
    endcase
  endfunction

  // intake and result checking
  always @(posedge clk) begin
    line_res_t r;
    bit acc;
    acc = 0;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        acc = 1;
        accepted++;
        if (search_step(cur_word.fn, cur_word.ch, r)) begin
          if (cur_word.typed) begin
            r.num = cur_word.num;
            r.hit = cur_word.hit;
          end
          line_q.push_back(r);
        end
      end
      if (out_valid && !out_stall) begin
        acc = 1;
        lines_seen++;
        if (out_line_matched) hits_seen++;
        if (line_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected line word: number %0d matched %0b", $time,
                   out_line_number, out_line_matched);
        end else begin
          r = line_q[0];
          line_q.delete(0);
          if (out_line_number !== r.num) begin
            errors++;
            $display("%0t: line_number expected %0d actual %0d", $time, r.num,
                     out_line_number);
          end
          if (out_line_matched !== r.hit) begin
            errors++;
            $display("%0t: line_matched expected %0b actual %0b (line %0d)", $time,
                     r.hit, out_line_matched, r.num);
          end
        end
      end
      idle_cycles = acc ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no progress for %0d cycles, %0d lines pending",
                 WATCHDOG_LIMIT, line_q.size());
        $display("code_only_phrase_search: mismatch");
        $finish;
      end
    end
  end

  // result side stalls
  initial begin
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  function automatic void put(logic [1:0] fn, logic [7:0] ch);
    src_word_t w;
    w = '{fn: fn, ch: ch, typed: 0, num: '0, hit: 0};
    feed_q.push_back(w);
  endfunction

  function automatic void put_text(string s);
    for (int k = 0; k < s.len(); k++) put(FUNC_CHAR, s[k]);
  endfunction

  function automatic logic [7:0] alpha_byte();
    return alpha[$urandom_range(0, alpha.len() - 1)];
  endfunction

  function automatic void gen_delim(int n);
    logic [7:0] c;
    for (int k = 0; k < n; k++) begin
      do c = alpha_byte(); while (c == CH_LPAR || c == CH_RPAR || c == " ");
      put(FUNC_CHAR, c);
    end
  endfunction

  // one source line built from C-like fragments
  function automatic void gen_line();
    int n, dl;
    logic [7:0] d [20];
    n = $urandom_range(0, 8);
    if ($urandom_range(0, 49) == 0) put(FUNC_SOF, 8'($urandom()));
    if ($urandom_range(0, 79) == 0) put(FUNC_UNUSED, 8'($urandom()));
    for (int t = 0; t < n; t++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          if ($urandom_range(0, 1)) put(FUNC_CHAR, alpha_byte());
          for (int j = 0; j < p_len && j < 16; j++) put(FUNC_CHAR, phrase[j]);
          if ($urandom_range(0, 1)) put(FUNC_CHAR, alpha_byte());
        end
        3: put_text("//");
        4: put_text($urandom_range(0, 1) ? "/*" : "*/");
        5, 6: begin
          put(FUNC_CHAR, (t % 2) ? CH_DQ : CH_SQ);
          repeat ($urandom_range(0, 3))
            put(FUNC_CHAR, $urandom_range(0, 2) ? alpha_byte() : CH_BSL);
          put(FUNC_CHAR, (t % 2) ? CH_DQ : CH_SQ);
        end
        7: begin
          dl = ($urandom_range(0, 29) == 0) ? $urandom_range(17, 20) : $urandom_range(0, 3);
          put_text("R\"");
          for (int k = 0; k < dl; k++) begin
            do d[k] = alpha_byte(); while (d[k] == CH_LPAR || d[k] == CH_RPAR);
            put(FUNC_CHAR, d[k]);
          end
          put(FUNC_CHAR, CH_LPAR);
          gen_delim($urandom_range(0, 3));
          if ($urandom_range(0, 3) != 0) begin
            put(FUNC_CHAR, CH_RPAR);
            for (int k = 0; k < dl; k++) put(FUNC_CHAR, d[k]);
            put(FUNC_CHAR, CH_DQ);
          end
        end
        8: put(FUNC_CHAR, 8'($urandom()));
        default: put(FUNC_CHAR, alpha_byte());
      endcase
    end
    put(FUNC_EOL, 8'($urandom()));
  endfunction

  task automatic cfg_write(cfg_reg_t idx, logic [63:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_PATTERN_LOW:    p_lo = v;
      CFG_PATTERN_HIGH:   p_hi = v;
      CFG_PATTERN_LENGTH: p_len = v[4:0];
      default:            p_ww = v[0];
    endcase
  endtask

  task automatic set_phrase(int len, bit ww, bit ones);
    logic [63:0] lo, hi;
    for (int j = 0; j < 16; j++) begin
      phrase[j] = ones ? 8'hFF : alpha_byte();
      if (j < 8) lo[j*8 +: 8] = phrase[j];
      else hi[(j-8)*8 +: 8] = phrase[j];
    end
    cfg_write(CFG_PATTERN_LOW, lo);
    cfg_write(CFG_PATTERN_HIGH, hi);
    cfg_write(CFG_PATTERN_LENGTH, 64'(len));
    cfg_write(CFG_WHOLE_WORD, 64'(ww));
    @(posedge clk);
  endtask

  task automatic drain();
    while (line_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic send_all(bit pause_mid);
    src_word_t w;
    int half;
    half = feed_q.size() / 2;
    for (int i = 0; feed_q.size() != 0; i++) begin
      w = feed_q[0];
      feed_q.delete(0);
      if (pause_mid && i == half) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (line_q.size() != 0) @(posedge clk);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      in_valid <= 1'b1;
      in_func <= w.fn;
      in_char_byte <= w.ch;
      cur_word <= w;
      @(posedge clk);
      while (in_stall) @(posedge clk);
    end
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int lens [6] = '{1, 16, 16, 3, 4, 9};
    search_reset();
    foreach (phrase[k]) phrase[k] = 8'h00;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[k]) feed_q.push_back(dir_tab[k]);
    send_all(0);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      calm = (ph == 5);
      set_phrase(lens[ph] == 9 ? $urandom_range(2, 16) : lens[ph],
                 (ph == 1 || ph == 3) ? 1'b1 :
                 (ph == 5 ? 1'($urandom_range(0, 1)) : 1'b0),
                 ph == 2);
      while (feed_q.size() < 320) gen_line();
      if (ph == 1) hold_req = 1;
      send_all(ph == 3);
      drain();
    end

    $display("run covered %0d words in, %0d line words out, %0d with a match,",
             accepted, lines_seen, hits_seen);
    $display("over comments, literals, raw strings and six phrase settings");
    if (errors == 0) begin
      $display("code_only_phrase_search: match");
    end else begin
      $display("code_only_phrase_search: mismatch");
    end
    $finish;
  end

endmodule
